// ===== rtl/rgba_unp_pkg.sv =====
package rgba_unp_pkg;

  // Field and counter widths
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned NUM_CH   = 3;
  localparam int unsigned NUM_CELLS = CHAN_W;   // one quotient bit per divider cell
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned PITCH_W  = 14;
  localparam int unsigned COL_W    = 13;
  localparam int unsigned ROW_W    = 12;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;

  // Clamp limits for the configured geometry
  localparam int unsigned MAX_WIDTH   = 4096;
  localparam int unsigned MAX_HEIGHT  = 4096;
  localparam int unsigned PITCH_LIMIT = 8192;

  localparam int unsigned CHAN_MAX = (1 << CHAN_W) - 1;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [PITCH_W-1:0] pitch_t;
  typedef logic [COL_W-1:0]   col_t;
  typedef logic [ROW_W-1:0]   row_t;

  // Configuration register indexes (byte address 4*index)
  typedef enum logic [1:0] {
    REG_WIDTH   = 2'd0,
    REG_HEIGHT  = 2'd1,
    REG_PITCH   = 2'd2,
    REG_PREMULT = 2'd3
  } reg_idx_e;

  typedef struct packed {
    dim_t   image_width;
    dim_t   image_height;
    pitch_t row_pitch_words;
    logic   source_premultiplied;
  } cfg_t;

  // One colour channel in flight through the divider chain
  typedef struct packed {
    chan_t rem;      // partial remainder, below alpha unless fix is set
    chan_t dq;       // dividend bits still to come, quotient bits shifted in
    logic  fix;      // result does not come from the division
    chan_t fix_val;  // result when fix is set
  } chan_st_t;

  typedef struct packed {
    chan_st_t [NUM_CH-1:0] ch;
    chan_t                 alpha;
    logic                  row_end;
    logic                  image_end;
  } pix_t;

endpackage

// ===== rtl/rgba_unp_front.sv =====
module rgba_unp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rgba_unp_pkg::cfg_t  cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rgba_unp_pkg::chan_t in_red_i,
  input  rgba_unp_pkg::chan_t in_green_i,
  input  rgba_unp_pkg::chan_t in_blue_i,
  input  rgba_unp_pkg::chan_t in_alpha_i,
  output logic                valid_o,
  output rgba_unp_pkg::pix_t  pix_o,
  input  logic                ready_i
);

  rgba_unp_pkg::col_t   col_q, col_d;
  rgba_unp_pkg::row_t   row_q, row_d;
  logic                 valid_q, valid_d;
  rgba_unp_pkg::pix_t   pix_q, pix_d;

  rgba_unp_pkg::dim_t   w_eff, h_eff;
  rgba_unp_pkg::pitch_t p_wide, p_eff;
  rgba_unp_pkg::pitch_t col_next;
  rgba_unp_pkg::dim_t   row_next;
  logic                 in_fire, is_pixel, last_col, last_row;
  rgba_unp_pkg::chan_t  colour [rgba_unp_pkg::NUM_CH];

  // Clamp the configured geometry
  always_comb begin
    if (cfg_i.image_width == '0) begin
      w_eff = rgba_unp_pkg::dim_t'(1);
    end else if (cfg_i.image_width > rgba_unp_pkg::dim_t'(rgba_unp_pkg::MAX_WIDTH)) begin
      w_eff = rgba_unp_pkg::dim_t'(rgba_unp_pkg::MAX_WIDTH);
    end else begin
      w_eff = cfg_i.image_width;
    end
    if (cfg_i.image_height == '0) begin
      h_eff = rgba_unp_pkg::dim_t'(1);
    end else if (cfg_i.image_height > rgba_unp_pkg::dim_t'(rgba_unp_pkg::MAX_HEIGHT)) begin
      h_eff = rgba_unp_pkg::dim_t'(rgba_unp_pkg::MAX_HEIGHT);
    end else begin
      h_eff = cfg_i.image_height;
    end
    p_wide = (cfg_i.row_pitch_words < {1'b0, w_eff}) ? {1'b0, w_eff} : cfg_i.row_pitch_words;
    p_eff  = (p_wide > rgba_unp_pkg::pitch_t'(rgba_unp_pkg::PITCH_LIMIT))
           ? rgba_unp_pkg::pitch_t'(rgba_unp_pkg::PITCH_LIMIT) : p_wide;
  end

  // Position of the current word in the row and image
  assign col_next = {1'b0, col_q} + rgba_unp_pkg::pitch_t'(1);
  assign row_next = {1'b0, row_q} + rgba_unp_pkg::dim_t'(1);
  assign is_pixel = (col_q < w_eff);
  assign last_col = (col_next == {1'b0, w_eff});
  assign last_row = (row_next >= h_eff);

  assign in_ready_o = !valid_q || ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Advance the counters on every accepted word, padding included
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_fire) begin
      if (col_next >= p_eff) begin
        col_d = '0;
        row_d = last_row ? '0 : row_next[rgba_unp_pkg::ROW_W-1:0];
      end else begin
        col_d = col_next[rgba_unp_pkg::COL_W-1:0];
      end
    end
  end

  assign colour[0] = in_red_i;
  assign colour[1] = in_green_i;
  assign colour[2] = in_blue_i;

  // Set up each channel: special alphas and overflow resolve here, the rest divides
  always_comb begin
    logic [2*rgba_unp_pkg::CHAN_W-1:0] scaled;
    logic [2*rgba_unp_pkg::CHAN_W-1:0] dividend;
    pix_d           = pix_q;
    pix_d.alpha     = in_alpha_i;
    pix_d.row_end   = last_col;
    pix_d.image_end = last_col && last_row;
    for (int i = 0; i < rgba_unp_pkg::NUM_CH; i++) begin
      scaled   = {colour[i], rgba_unp_pkg::chan_t'(0)} - {rgba_unp_pkg::chan_t'(0), colour[i]};
      dividend = scaled + {rgba_unp_pkg::chan_t'(0), 1'b0, in_alpha_i[rgba_unp_pkg::CHAN_W-1:1]};
      pix_d.ch[i].rem = dividend[2*rgba_unp_pkg::CHAN_W-1:rgba_unp_pkg::CHAN_W];
      pix_d.ch[i].dq  = dividend[rgba_unp_pkg::CHAN_W-1:0];
      if (!cfg_i.source_premultiplied
          || in_alpha_i == rgba_unp_pkg::chan_t'(rgba_unp_pkg::CHAN_MAX)) begin
        pix_d.ch[i].fix     = 1'b1;
        pix_d.ch[i].fix_val = colour[i];
      end else if (in_alpha_i == '0) begin
        pix_d.ch[i].fix     = 1'b1;
        pix_d.ch[i].fix_val = '0;
      end else if (dividend[2*rgba_unp_pkg::CHAN_W-1:rgba_unp_pkg::CHAN_W] >= in_alpha_i) begin
        // quotient would reach 256: saturate
        pix_d.ch[i].fix     = 1'b1;
        pix_d.ch[i].fix_val = rgba_unp_pkg::chan_t'(rgba_unp_pkg::CHAN_MAX);
      end else begin
        pix_d.ch[i].fix     = 1'b0;
        pix_d.ch[i].fix_val = '0;
      end
    end
  end

  // Drop padding words, pass pixels on
  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_fire && is_pixel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && is_pixel) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

endmodule

// ===== rtl/rgba_unp_cell.sv =====
module rgba_unp_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  rgba_unp_pkg::pix_t pix_i,
  output logic               ready_o,
  output logic               valid_o,
  output rgba_unp_pkg::pix_t pix_o,
  input  logic               ready_i
);

  logic               valid_q, valid_d;
  rgba_unp_pkg::pix_t pix_q, pix_d;
  logic               load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // One restoring-division step per channel: bring down a dividend bit, try alpha
  always_comb begin
    logic [rgba_unp_pkg::CHAN_W:0] trial;
    logic                          ge;
    pix_d = pix_i;
    for (int i = 0; i < rgba_unp_pkg::NUM_CH; i++) begin
      trial = {pix_i.ch[i].rem, pix_i.ch[i].dq[rgba_unp_pkg::CHAN_W-1]};
      ge    = (trial >= {1'b0, pix_i.alpha});
      if (ge) begin
        trial = trial - {1'b0, pix_i.alpha};
      end
      pix_d.ch[i].rem = trial[rgba_unp_pkg::CHAN_W-1:0];
      pix_d.ch[i].dq  = {pix_i.ch[i].dq[rgba_unp_pkg::CHAN_W-2:0], ge};
    end
  end

  // Hold while downstream stalls, take a new transaction when free
  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |=> (valid_q && $stable(pix_q)))
    else $error("cell lost or changed a stalled transaction");

  a_take_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> valid_q)
    else $error("cell dropped an accepted transaction");

endmodule

// ===== rtl/rgba_alpha_unpremultiply_rows_core.sv =====
// Alpha unpremultiply of an RGBA8888 stream laid out in rows. Source words
// are taken one per clock while in_ready_o is high; the first image_width
// words of each row_pitch_words-long row are pixels, the rest are padding
// and are consumed without a result. Pixels give one result each, one per
// clock sustained while the output is not stalled, through an entry
// register, a chain of eight divider cells that each produce one quotient
// bit for all three colour channels, and an output register. Each stage
// stalls only when the stage after it is full, so a stalled output does not
// block input until the chain fills. row_end and image_end flag the last
// pixel of a row and of the image. Registers (APB, byte address 4*index):
// image_width, image_height, row_pitch_words, source_premultiplied; write
// them only while the block is idle.
module rgba_alpha_unpremultiply_rows_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // configuration port
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [rgba_unp_pkg::ADDR_W-1:0]         paddr,
  input  logic [rgba_unp_pkg::DATA_W-1:0]         pwdata,
  output logic [rgba_unp_pkg::DATA_W-1:0]         prdata,
  output logic                                    pready,
  // input pixels
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [7:0]                              in_red_i,
  input  logic [7:0]                              in_green_i,
  input  logic [7:0]                              in_blue_i,
  input  logic [7:0]                              in_alpha_i,
  // output pixels
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [7:0]                              out_red_o,
  output logic [7:0]                              out_green_o,
  output logic [7:0]                              out_blue_o,
  output logic [7:0]                              out_alpha_o,
  output logic                                    row_end_o,
  output logic                                    image_end_o
);

  rgba_unp_pkg::cfg_t     cfg_q;
  rgba_unp_pkg::reg_idx_e reg_idx;
  logic                   cfg_wr;

  logic                   chain_valid [rgba_unp_pkg::NUM_CELLS+1];
  logic                   chain_ready [rgba_unp_pkg::NUM_CELLS+1];
  rgba_unp_pkg::pix_t     chain_pix   [rgba_unp_pkg::NUM_CELLS+1];

  logic                   out_valid_q, out_valid_d;
  rgba_unp_pkg::chan_t    out_ch_q [rgba_unp_pkg::NUM_CH];
  rgba_unp_pkg::chan_t    out_alpha_q;
  logic                   out_row_end_q, out_image_end_q;
  logic                   out_load;

  // Register file
  assign pready  = 1'b1;
  assign reg_idx = rgba_unp_pkg::reg_idx_e'(paddr[rgba_unp_pkg::ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width          <= rgba_unp_pkg::dim_t'(1);
      cfg_q.image_height         <= rgba_unp_pkg::dim_t'(1);
      cfg_q.row_pitch_words      <= rgba_unp_pkg::pitch_t'(1);
      cfg_q.source_premultiplied <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rgba_unp_pkg::REG_WIDTH: begin
          cfg_q.image_width <= pwdata[rgba_unp_pkg::DIM_W-1:0];
        end
        rgba_unp_pkg::REG_HEIGHT: begin
          cfg_q.image_height <= pwdata[rgba_unp_pkg::DIM_W-1:0];
        end
        rgba_unp_pkg::REG_PITCH: begin
          cfg_q.row_pitch_words <= pwdata[rgba_unp_pkg::PITCH_W-1:0];
        end
        rgba_unp_pkg::REG_PREMULT: begin
          cfg_q.source_premultiplied <= pwdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      rgba_unp_pkg::REG_WIDTH: begin
        prdata = rgba_unp_pkg::DATA_W'(cfg_q.image_width);
      end
      rgba_unp_pkg::REG_HEIGHT: begin
        prdata = rgba_unp_pkg::DATA_W'(cfg_q.image_height);
      end
      rgba_unp_pkg::REG_PITCH: begin
        prdata = rgba_unp_pkg::DATA_W'(cfg_q.row_pitch_words);
      end
      rgba_unp_pkg::REG_PREMULT: begin
        prdata = rgba_unp_pkg::DATA_W'(cfg_q.source_premultiplied);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  // Counters and channel setup
  rgba_unp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_red_i   (in_red_i),
    .in_green_i (in_green_i),
    .in_blue_i  (in_blue_i),
    .in_alpha_i (in_alpha_i),
    .valid_o    (chain_valid[0]),
    .pix_o      (chain_pix[0]),
    .ready_i    (chain_ready[0])
  );

  // Divider chain, one quotient bit per cell
  for (genvar k = 0; k < rgba_unp_pkg::NUM_CELLS; k++) begin : g_cell
    rgba_unp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[k]),
      .pix_i   (chain_pix[k]),
      .ready_o (chain_ready[k]),
      .valid_o (chain_valid[k+1]),
      .pix_o   (chain_pix[k+1]),
      .ready_i (chain_ready[k+1])
    );
  end

  // Output register: pick quotient or fixed value
  assign chain_ready[rgba_unp_pkg::NUM_CELLS] = !out_valid_q || out_ready_i;
  assign out_load = chain_valid[rgba_unp_pkg::NUM_CELLS] && chain_ready[rgba_unp_pkg::NUM_CELLS];

  always_comb begin
    out_valid_d = out_valid_q;
    if (chain_ready[rgba_unp_pkg::NUM_CELLS]) begin
      out_valid_d = chain_valid[rgba_unp_pkg::NUM_CELLS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int i = 0; i < rgba_unp_pkg::NUM_CH; i++) begin
        out_ch_q[i] <= chain_pix[rgba_unp_pkg::NUM_CELLS].ch[i].fix
                     ? chain_pix[rgba_unp_pkg::NUM_CELLS].ch[i].fix_val
                     : chain_pix[rgba_unp_pkg::NUM_CELLS].ch[i].dq;
      end
      out_alpha_q     <= chain_pix[rgba_unp_pkg::NUM_CELLS].alpha;
      out_row_end_q   <= chain_pix[rgba_unp_pkg::NUM_CELLS].row_end;
      out_image_end_q <= chain_pix[rgba_unp_pkg::NUM_CELLS].image_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_ch_q[0];
  assign out_green_o = out_ch_q[1];
  assign out_blue_o  = out_ch_q[2];
  assign out_alpha_o = out_alpha_q;
  assign row_end_o   = out_row_end_q;
  assign image_end_o = out_image_end_q;

  a_image_end_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && image_end_o) |-> row_end_o)
    else $error("image end flagged on a pixel that does not end a row");

endmodule
